[sv/rcd_pkg.sv]
// Package for the chunk-stream deframer: header constants, chunk size limits
// and the result record. It depends on nothing else.
package rcd_pkg;

  // Basic header classification on the top two bits.
  localparam logic [7:0] KIND_MASK  = 8'hC0;
  localparam logic [7:0] KIND_LONG  = 8'h00;
  localparam logic [7:0] KIND_SHORT = 8'h40;

  // Message header sizes and the positions of the fields that are kept.
  localparam logic [3:0] HDR_LONG_SIZE  = 4'd11;
  localparam logic [3:0] HDR_SHORT_SIZE = 4'd7;
  localparam logic [3:0] LEN_FIRST_IDX  = 4'd3;
  localparam logic [3:0] LEN_LAST_IDX   = 4'd5;
  localparam logic [3:0] TYPE_IDX       = 4'd6;

  // Chunk size register limits.
  localparam int unsigned CHUNK_W = 13;
  localparam logic [CHUNK_W-1:0] CHUNK_MAX   = 13'd4096;
  localparam logic [CHUNK_W-1:0] CHUNK_MIN   = 13'd1;
  localparam logic [CHUNK_W-1:0] CHUNK_RESET = 13'd128;

  // One deframed payload byte with its message context.
  typedef struct packed {
    logic [7:0]  payload_byte;
    logic [7:0]  message_type;
    logic [23:0] message_length;
    logic        last_of_message;
  } result_t;

endpackage

[sv/rtmp_chunk_deframer.sv]
// Top level of the chunk-stream deframer: parser, result queue and output
// register. Depends on rcd_pkg, rcd_front, rcd_queue and rcd_back.
//
// Usage: received stream bytes enter on in_valid/in_byte, one transaction per
// byte; the block raises in_stall only when its result queue is full.
// Deframed payload bytes leave on out_valid with payload_byte, message_type,
// message_length and last_of_message; the receiver holds a transaction with
// out_stall and the payload stays put until it is taken.
// Headers, unknown basic header bytes and continuation bytes are consumed
// without a result. The user must write the chunk size register with
// cfg_write and cfg_data only while the block is idle; the block itself
// does not enforce this. 0 acts as 1 and values above 4096 act as 4096.
// Throughput: one byte per cycle while in_stall is low.
// A payload byte is written into the queue and then loaded into the output
// register before it is presented on out_valid.
// While the receiver stalls, the queue (QUEUE_DEPTH entries) plus the output
// register absorb results before in_stall rises.
// Reset (rst, synchronous) empties the queue, returns the parser to waiting
// for a basic header and sets the chunk size to 128.
module rtmp_chunk_deframer #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [rcd_pkg::CHUNK_W-1:0]  cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   in_byte,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   payload_byte,
  output logic [7:0]                   message_type,
  output logic [23:0]                  message_length,
  output logic                         last_of_message
);

  rcd_pkg::result_t       push_data;
  rcd_pkg::result_t       pop_data;
  rcd_pkg::result_t       out_data;
  logic                   q_push;
  logic                   q_pop;
  logic                   q_full;
  logic                   q_empty;
  logic                   accept;

  // Bytes are taken whenever the queue has room.
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  rcd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .in_byte   (in_byte),
    .push      (q_push),
    .push_data (push_data)
  );

  rcd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_data),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  rcd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (q_empty),
    .pop_data  (pop_data),
    .pop       (q_pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  assign payload_byte    = out_data.payload_byte;
  assign message_type    = out_data.message_type;
  assign message_length  = out_data.message_length;
  assign last_of_message = out_data.last_of_message;

  // The parser never writes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("result written into a full queue");

  // The output stage never reads an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("result read from an empty queue");

  // A waiting result reaches the output register once it is free.
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (!q_empty && (!out_valid || !out_stall)) |=> out_valid)
    else $error("queued result not moved to the output");

  // A result pushed into an empty queue with a free output reaches out_valid.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (q_push && q_empty && !out_valid) |=> ##1 out_valid)
    else $error("result latency exceeded");

endmodule

[sv/rcd_front.sv]
// Front end of the deframer: the chunk size register and the byte parser
// that classifies each received byte. Depends on rcd_pkg.
module rcd_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [rcd_pkg::CHUNK_W-1:0]   cfg_data,
  input  logic                          accept,
  input  logic [7:0]                    in_byte,
  output logic                          push,
  output rcd_pkg::result_t              push_data
);

  typedef enum logic [1:0] {
    IDLE,
    HEADER,
    PAYLOAD,
    SKIP
  } phase_t;

  phase_t                       phase, phase_next;
  logic [rcd_pkg::CHUNK_W-1:0]  chunk_size;
  logic [3:0]                   hdr_count, hdr_count_next;
  logic                         hdr_long, hdr_long_next;
  logic [23:0]                  msg_length, msg_length_next;
  logic [7:0]                   msg_type, msg_type_next;
  logic [23:0]                  remaining, remaining_next;
  logic [rcd_pkg::CHUNK_W-1:0]  chunk_count, chunk_count_next;
  logic [rcd_pkg::CHUNK_W-1:0]  eff_chunk;
  logic [rcd_pkg::CHUNK_W-1:0]  chunk_inc;
  logic [3:0]                   hdr_inc;
  logic [3:0]                   hdr_size;
  logic [7:0]                   kind;
  logic                         last;

  // Clamp the programmed chunk size into its legal range.
  always_comb begin
    if (chunk_size == '0) begin
      eff_chunk = rcd_pkg::CHUNK_MIN;
    end else if (chunk_size > rcd_pkg::CHUNK_MAX) begin
      eff_chunk = rcd_pkg::CHUNK_MAX;
    end else begin
      eff_chunk = chunk_size;
    end
  end

  assign kind      = in_byte & rcd_pkg::KIND_MASK;
  assign hdr_inc   = hdr_count + 4'd1;
  assign hdr_size  = hdr_long ? rcd_pkg::HDR_LONG_SIZE : rcd_pkg::HDR_SHORT_SIZE;
  assign chunk_inc = chunk_count + 13'd1;
  assign last      = (remaining <= 24'd1);

  // Classify the byte and work out the next parser state.
  always_comb begin
    phase_next       = phase;
    hdr_count_next   = hdr_count;
    hdr_long_next    = hdr_long;
    msg_length_next  = msg_length;
    msg_type_next    = msg_type;
    remaining_next   = remaining;
    chunk_count_next = chunk_count;
    push             = 1'b0;
    case (phase)
      IDLE: begin
        if (kind == rcd_pkg::KIND_LONG || kind == rcd_pkg::KIND_SHORT) begin
          hdr_long_next   = (kind == rcd_pkg::KIND_LONG);
          hdr_count_next  = 4'd0;
          msg_length_next = 24'd0;
          msg_type_next   = 8'd0;
          phase_next      = HEADER;
        end
      end
      HEADER: begin
        if (hdr_count >= rcd_pkg::LEN_FIRST_IDX && hdr_count <= rcd_pkg::LEN_LAST_IDX) begin
          msg_length_next = {msg_length[15:0], in_byte};
        end else if (hdr_count == rcd_pkg::TYPE_IDX) begin
          msg_type_next = in_byte;
        end
        hdr_count_next = hdr_inc;
        if (hdr_inc >= hdr_size) begin
          chunk_count_next = '0;
          remaining_next   = msg_length_next;
          phase_next       = (msg_length_next == 24'd0) ? IDLE : PAYLOAD;
        end
      end
      PAYLOAD: begin
        push           = accept;
        remaining_next = remaining - 24'd1;
        if (last) begin
          phase_next = IDLE;
        end else if (chunk_inc >= eff_chunk) begin
          chunk_count_next = '0;
          phase_next       = SKIP;
        end else begin
          chunk_count_next = chunk_inc;
        end
      end
      SKIP: begin
        // The continuation byte is dropped without a check.
        phase_next = PAYLOAD;
      end
      default: begin
        phase_next = IDLE;
      end
    endcase
  end

  // The result record carries the current message context.
  assign push_data.payload_byte    = in_byte;
  assign push_data.message_type    = msg_type;
  assign push_data.message_length  = msg_length;
  assign push_data.last_of_message = last;

  // Parser state and the configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= IDLE;
      chunk_size <= rcd_pkg::CHUNK_RESET;
    end else begin
      if (cfg_write) begin
        chunk_size <= cfg_data;
      end
      if (accept) begin
        phase <= phase_next;
      end
    end
  end

  // Message context registers follow the accepted bytes.
  always_ff @(posedge clk) begin
    if (accept) begin
      hdr_count   <= hdr_count_next;
      hdr_long    <= hdr_long_next;
      msg_length  <= msg_length_next;
      msg_type    <= msg_type_next;
      remaining   <= remaining_next;
      chunk_count <= chunk_count_next;
    end
  end

endmodule

[sv/rcd_queue.sv]
// Short result queue between the parser and the output stage.
// Depends on rcd_pkg for the result record.
module rcd_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  rcd_pkg::result_t push_data,
  input  logic             pop,
  output rcd_pkg::result_t pop_data,
  output logic             full,
  output logic             empty
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  rcd_pkg::result_t  entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full     = (count == CNT_FULL);
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

[sv/rcd_back.sv]
// Output stage of the deframer: a result register that drains the queue
// and holds a transaction while the receiver stalls. Depends on rcd_pkg.
module rcd_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             empty,
  input  rcd_pkg::result_t pop_data,
  output logic             pop,
  input  logic             out_stall,
  output logic             out_valid,
  output rcd_pkg::result_t out_data
);

  // Load a new result whenever the register is free or being taken.
  assign pop = !empty && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= !empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= pop_data;
    end
  end

endmodule
